// ===== design/uitfr_pkg.sv =====
package uitfr_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned IDLE_W = 16;
  localparam int unsigned CNT_OUT_W = 7;

  localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = 16'd50;
  localparam logic [IDLE_W-1:0] IDLE_WRAP      = 16'd60000;
  localparam int unsigned       PREFIX_MIN     = 4;
  localparam int unsigned       TRAILER_MIN    = 2;

  localparam logic [DATA_W-1:0] CH_PLUS = 8'h2b;
  localparam logic [DATA_W-1:0] CH_W    = 8'h57;
  localparam logic [DATA_W-1:0] CH_A    = 8'h41;
  localparam logic [DATA_W-1:0] CH_O    = 8'h4f;
  localparam logic [DATA_W-1:0] CH_K    = 8'h4b;
  localparam logic [DATA_W-1:0] CH_GS   = 8'h1d;
  localparam logic [DATA_W-1:0] CH_CR   = 8'h0d;
  localparam logic [DATA_W-1:0] CH_LF   = 8'h0a;

endpackage

// ===== design/uitfr_in_if.sv =====
interface uitfr_in_if;
  logic                              valid;
  logic                              ready;
  logic [uitfr_pkg::CMD_W-1:0]       command;
  logic [uitfr_pkg::DATA_W-1:0]      data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

// ===== design/uitfr_out_if.sv =====
interface uitfr_out_if;
  logic                              valid;
  logic                              ready;
  logic                              frame_complete;
  logic [uitfr_pkg::CNT_OUT_W-1:0]   byte_count;
  logic                              reply_ok;
  logic                              command_end;
  logic                              line_end;

  modport source (output valid, frame_complete, byte_count, reply_ok, command_end, line_end,
                  input ready);
  modport sink   (input valid, frame_complete, byte_count, reply_ok, command_end, line_end,
                  output ready);
endinterface

// ===== design/uart_idle_timeout_frame_receiver.sv =====
// a result word is registered and valid in the cycle after its input word is accepted
// throughput: one word per cycle while the result side takes each result; state update and
//   classification are one pass from the state registers into the output register
// a new word is taken in the cycle the held result leaves; while it waits the input is held off
// reset (rst_n low, synchronous): buffer, count, idle counter and flags cleared,
//   idle_limit back to 50, no result valid
module uart_idle_timeout_frame_receiver #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  uitfr_in_if.sink                        in_ch,
  uitfr_out_if.source                     out_ch,
  input  logic                            cfg_wr_en,
  input  logic [uitfr_pkg::IDLE_W-1:0]    cfg_wr_data
);

  localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned DW    = uitfr_pkg::DATA_W;
  localparam int unsigned IW    = uitfr_pkg::IDLE_W;
  localparam int unsigned OW    = uitfr_pkg::CNT_OUT_W;

  // only the first three slots and the last two written slots are ever looked at
  logic [DW-1:0]    head0_r, head1_r, head2_r, prev_r, last_r;
  logic [DW-1:0]    head0_nxt, head1_nxt, head2_nxt, prev_nxt, last_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IW-1:0]    idle_r, idle_nxt, idle_mid;
  logic             pending_r, pending_nxt;
  logic             armed_r, armed_nxt;
  logic             mark_r, mark_nxt;
  logic [IW-1:0]    limit_r;

  logic             out_valid_r;
  logic             ok_r, cmd_end_r, line_end_r;
  logic             ok_nxt, cmd_end_nxt, line_end_nxt;
  logic [CNT_W+OW-1:0] count_ext;

  logic             in_fire;
  logic             full;
  logic             ok_hit, cmd_hit, nl_hit;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(BUFFER_DEPTH));

  // classification of the held frame
  assign ok_hit = (count_r >= CNT_W'(uitfr_pkg::PREFIX_MIN)) &&
                  ((head0_r == uitfr_pkg::CH_PLUS && head1_r == uitfr_pkg::CH_W &&
                    head2_r == uitfr_pkg::CH_A) ||
                   (head0_r == uitfr_pkg::CH_O && head1_r == uitfr_pkg::CH_K));
  assign cmd_hit = (count_r >= CNT_W'(uitfr_pkg::TRAILER_MIN)) &&
                   prev_r == uitfr_pkg::CH_GS && last_r == uitfr_pkg::CH_CR;
  assign nl_hit  = (count_r >= CNT_W'(uitfr_pkg::TRAILER_MIN)) &&
                   prev_r == uitfr_pkg::CH_CR && last_r == uitfr_pkg::CH_LF;

  always_comb begin
    head0_nxt    = head0_r;
    head1_nxt    = head1_r;
    head2_nxt    = head2_r;
    prev_nxt     = prev_r;
    last_nxt     = last_r;
    count_nxt    = count_r;
    idle_nxt     = idle_r;
    idle_mid     = idle_r;
    pending_nxt  = pending_r;
    armed_nxt    = armed_r;
    mark_nxt     = mark_r;
    ok_nxt       = 1'b0;
    cmd_end_nxt  = 1'b0;
    line_end_nxt = 1'b0;
    unique case (in_ch.command)
      uitfr_pkg::CMD_BYTE: begin
        idle_nxt    = '0;
        pending_nxt = 1'b1;
        mark_nxt    = 1'b0;
        last_nxt    = in_ch.data_byte;
        if (!full) begin
          count_nxt = count_r + CNT_W'(1);
          prev_nxt  = last_r;
          if (count_r == CNT_W'(0)) head0_nxt = in_ch.data_byte;
          if (count_r == CNT_W'(1)) head1_nxt = in_ch.data_byte;
          if (count_r == CNT_W'(2)) head2_nxt = in_ch.data_byte;
        end
      end
      uitfr_pkg::CMD_TICK: begin
        if (pending_r) begin
          armed_nxt = 1'b1;
          if (idle_r > limit_r) begin
            idle_mid    = '0;
            pending_nxt = 1'b0;
            mark_nxt    = 1'b1;
          end
        end else if (armed_r) begin
          armed_nxt    = 1'b0;
          ok_nxt       = ok_hit;
          cmd_end_nxt  = cmd_hit;
          line_end_nxt = nl_hit;
        end
        // counter restarts once it passes the wrap point
        if (idle_mid > uitfr_pkg::IDLE_WRAP) idle_mid = '0;
        idle_nxt = idle_mid + IW'(1);
      end
      uitfr_pkg::CMD_CLEAR: begin
        head0_nxt = '0;
        head1_nxt = '0;
        head2_nxt = '0;
        prev_nxt  = '0;
        last_nxt  = '0;
        count_nxt = '0;
        mark_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head0_r     <= '0;
      head1_r     <= '0;
      head2_r     <= '0;
      prev_r      <= '0;
      last_r      <= '0;
      count_r     <= '0;
      idle_r      <= '0;
      pending_r   <= 1'b0;
      armed_r     <= 1'b0;
      mark_r      <= 1'b0;
      limit_r     <= uitfr_pkg::IDLE_LIMIT_RST;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
      cmd_end_r   <= 1'b0;
      line_end_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (in_fire) begin
        head0_r     <= head0_nxt;
        head1_r     <= head1_nxt;
        head2_r     <= head2_nxt;
        prev_r      <= prev_nxt;
        last_r      <= last_nxt;
        count_r     <= count_nxt;
        idle_r      <= idle_nxt;
        pending_r   <= pending_nxt;
        armed_r     <= armed_nxt;
        mark_r      <= mark_nxt;
        ok_r        <= ok_nxt;
        cmd_end_r   <= cmd_end_nxt;
        line_end_r  <= line_end_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // count and level flag are the state itself, so they sit in the output word directly
  assign count_ext             = {{OW{1'b0}}, count_r};
  assign out_ch.valid          = out_valid_r;
  assign out_ch.frame_complete = mark_r;
  assign out_ch.byte_count     = count_ext[OW-1:0];
  assign out_ch.reply_ok       = ok_r;
  assign out_ch.command_end    = cmd_end_r;
  assign out_ch.line_end       = line_end_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(BUFFER_DEPTH))
    else $error("byte count above buffer depth");

  a_idle_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idle_r <= uitfr_pkg::IDLE_WRAP + IW'(1))
    else $error("idle counter past wrap point");

  a_mark_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
    mark_r |-> !pending_r)
    else $error("frame complete while still pending");

  a_pulse_after_classify: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (ok_r || cmd_end_r || line_end_r)) |-> (!armed_r && !pending_r))
    else $error("classification pulse without a finished classification");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted word produced no result");

endmodule

// ===== tb/uitfr_frame_checker.sv =====
`timescale 1ns / 100ps

module uitfr_frame_checker #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  uitfr_in_if                          in_mon,
  uitfr_out_if                         out_mon,
  input  logic                         cfg_wr_en,
  input  logic [uitfr_pkg::IDLE_W-1:0] cfg_wr_data,
  output int unsigned                  mismatch_count,
  output int unsigned                  pending_count
);

  localparam int unsigned DW = uitfr_pkg::DATA_W;
  localparam int unsigned IW = uitfr_pkg::IDLE_W;
  localparam int unsigned CW = uitfr_pkg::CMD_W;
  localparam int unsigned OW = uitfr_pkg::CNT_OUT_W;

  typedef struct packed {
    logic          frame_complete;
    logic [OW-1:0] byte_count;
    logic          reply_ok;
    logic          command_end;
    logic          line_end;
  } frame_status_t;

  logic [DW-1:0] rx_buf [BUFFER_DEPTH];
  int unsigned   rx_count;
  logic [IW-1:0] idle_cnt;
  logic          frame_pend;
  logic          class_armed;
  logic          done_mark;
  logic [IW-1:0] limit_reg;
  frame_status_t status_q [$];
  frame_status_t got;
  frame_status_t want;

  function automatic void wipe_buffer();
    for (int i = 0; i < BUFFER_DEPTH; i++) rx_buf[i] = '0;
    rx_count = 0;
  endfunction

  function automatic frame_status_t next_status(input logic [CW-1:0] cmd,
                                                input logic [DW-1:0] data);
    frame_status_t st;
    int unsigned   n;
    st = '0;
    case (cmd)
      uitfr_pkg::CMD_BYTE: begin
        idle_cnt   = '0;
        frame_pend = 1'b1;
        done_mark  = 1'b0;
        if (rx_count < BUFFER_DEPTH) rx_count++;
        // full buffer: the newest byte keeps landing in the last slot
        rx_buf[rx_count-1] = data;
      end
      uitfr_pkg::CMD_TICK: begin
        if (frame_pend) begin
          class_armed = 1'b1;
          if (idle_cnt > limit_reg) begin
            idle_cnt   = '0;
            frame_pend = 1'b0;
            done_mark  = 1'b1;
          end
        end else if (class_armed) begin
          class_armed = 1'b0;
          n = rx_count;
          if (n >= uitfr_pkg::PREFIX_MIN &&
              ((rx_buf[0] == uitfr_pkg::CH_PLUS && rx_buf[1] == uitfr_pkg::CH_W &&
                rx_buf[2] == uitfr_pkg::CH_A) ||
               (rx_buf[0] == uitfr_pkg::CH_O && rx_buf[1] == uitfr_pkg::CH_K)))
            st.reply_ok = 1'b1;
          if (n >= uitfr_pkg::TRAILER_MIN) begin
            st.command_end = (rx_buf[n-2] == uitfr_pkg::CH_GS) &&
                             (rx_buf[n-1] == uitfr_pkg::CH_CR);
            st.line_end    = (rx_buf[n-2] == uitfr_pkg::CH_CR) &&
                             (rx_buf[n-1] == uitfr_pkg::CH_LF);
          end
        end
        if (idle_cnt > uitfr_pkg::IDLE_WRAP) idle_cnt = '0;
        idle_cnt = idle_cnt + 1'b1;
      end
      uitfr_pkg::CMD_CLEAR: begin
        wipe_buffer();
        done_mark = 1'b0;
      end
      default: ;
    endcase
    st.frame_complete = done_mark;
    st.byte_count     = rx_count[OW-1:0];
    return st;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      wipe_buffer();
      idle_cnt    = '0;
      frame_pend  = 1'b0;
      class_armed = 1'b0;
      done_mark   = 1'b0;
      limit_reg   = uitfr_pkg::IDLE_LIMIT_RST;
      status_q.delete();
      mismatch_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.frame_complete, out_mon.byte_count, out_mon.reply_ok,
               out_mon.command_end, out_mon.line_end};
        if (status_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result word with nothing expected: complete=%0d count=%0d",
                     $time, got.frame_complete, got.byte_count);
          mismatch_count++;
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10) begin
              $write("%0t: mismatch exp complete=%0d count=%0d ok=%0d", $time,
                     want.frame_complete, want.byte_count, want.reply_ok);
              $write(" cmd_end=%0d line_end=%0d | got complete=%0d count=%0d",
                     want.command_end, want.line_end,
                     got.frame_complete, got.byte_count);
              $display(" ok=%0d cmd_end=%0d line_end=%0d",
                       got.reply_ok, got.command_end, got.line_end);
            end
            mismatch_count++;
          end
        end
      end
      if (cfg_wr_en) limit_reg = cfg_wr_data;
      if (in_mon.valid && in_mon.ready)
        status_q.push_back(next_status(in_mon.command, in_mon.data_byte));
    end
    pending_count = status_q.size();
  end

endmodule

// ===== tb/uart_idle_timeout_frame_receiver_tb.sv =====
`timescale 1ns / 100ps

module uart_idle_timeout_frame_receiver_tb;

  localparam int unsigned   CW          = uitfr_pkg::CMD_W;
  localparam int unsigned   DW          = uitfr_pkg::DATA_W;
  localparam int unsigned   IW          = uitfr_pkg::IDLE_W;
  localparam int unsigned   DEPTH       = 64;
  localparam logic [CW-1:0] CMD_UNUSED  = 2'd3;
  localparam int unsigned   LONG_HOLD   = 200;
  localparam int unsigned   PHASE_WORDS = 385;
  localparam int unsigned   CYCLE_LIMIT = 1_000_000;
  localparam int unsigned   TOP_TICKS   = 16;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [IW-1:0]     cfg_wr_data;
  int unsigned       mismatch_count;
  int unsigned       pending_count;
  int unsigned       cycle_cnt = 0;
  int unsigned       word_count = 0;
  int unsigned       src_idle_pct;
  int unsigned       sink_stall_pct;
  int unsigned       cur_limit;
  int unsigned       hold_req;

  uitfr_in_if  in_ch();
  uitfr_out_if out_ch();

  uart_idle_timeout_frame_receiver #(
    .BUFFER_DEPTH(DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  uitfr_frame_checker #(
    .BUFFER_DEPTH(DEPTH)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : sink_side
    int unsigned hold_n;
    int unsigned hold_done;
    hold_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        out_ch.ready <= 1'b0;
        for (hold_n = 0; hold_n < LONG_HOLD; hold_n++) @(negedge clk);
        hold_done++;
      end
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // entered and left at a falling edge; valid stays high into the next word
  task automatic offer_word(input logic [CW-1:0] cmd, input logic [DW-1:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.data_byte <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (cmd != CMD_UNUSED) word_count++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_idle_limit(input int unsigned value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[IW-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    cur_limit = value;
  endtask

  task automatic offer_ticks(input int unsigned count);
    repeat (count) offer_word(uitfr_pkg::CMD_TICK, DW'($urandom_range(255)));
  endtask

  // mostly well-formed frames: bytes, then enough ticks to time out and classify
  task automatic feed_frame();
    logic [DW-1:0] body [$];
    int unsigned   mid_len;
    int unsigned   n_ticks;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 8))
        offer_word(CW'($urandom_range(3)), DW'($urandom_range(255)));
      return;
    end
    if ($urandom_range(1)) offer_word(uitfr_pkg::CMD_CLEAR, DW'($urandom_range(255)));
    case ($urandom_range(4))
      1: begin
        body.push_back(uitfr_pkg::CH_PLUS);
        body.push_back(uitfr_pkg::CH_W);
        body.push_back(uitfr_pkg::CH_A);
      end
      2: begin body.push_back(uitfr_pkg::CH_O); body.push_back(uitfr_pkg::CH_K); end
      // broken prefixes
      3: begin body.push_back(uitfr_pkg::CH_PLUS); body.push_back(uitfr_pkg::CH_W); end
      4: body.push_back(uitfr_pkg::CH_O);
      default: ;
    endcase
    mid_len = ($urandom_range(9) == 0) ? $urandom_range(55, 70) : $urandom_range(5);
    repeat (mid_len) body.push_back(DW'($urandom_range(255)));
    case ($urandom_range(4))
      1: begin body.push_back(uitfr_pkg::CH_GS); body.push_back(uitfr_pkg::CH_CR); end
      2: begin body.push_back(uitfr_pkg::CH_CR); body.push_back(uitfr_pkg::CH_LF); end
      3: begin body.push_back(uitfr_pkg::CH_LF); body.push_back(uitfr_pkg::CH_CR); end
      4: body.push_back(uitfr_pkg::CH_CR);
      default: ;
    endcase
    foreach (body[i]) begin
      offer_word(uitfr_pkg::CMD_BYTE, body[i]);
      if ($urandom_range(19) == 0) offer_word(uitfr_pkg::CMD_TICK, DW'($urandom_range(255)));
    end
    if ($urandom_range(9) == 0) n_ticks = $urandom_range(cur_limit + 1);
    else n_ticks = cur_limit + 3 + $urandom_range(2);
    offer_ticks(n_ticks);
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned sink_pct,
                           input int unsigned limit, input logic with_hold);
    int unsigned start_cnt;
    drain_results();
    write_idle_limit(limit);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    // input keeps coming while the result side holds off
    if (with_hold) hold_req++;
    start_cnt = word_count;
    while (word_count - start_cnt < PHASE_WORDS) feed_frame();
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.command   = uitfr_pkg::CMD_BYTE;
    in_ch.data_byte = '0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    hold_req        = 0;
    cur_limit       = 32'(uitfr_pkg::IDLE_LIMIT_RST);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // limit still at its reset value
    offer_word(CMD_UNUSED, 8'hff);
    offer_word(uitfr_pkg::CMD_TICK, 8'h00);
    offer_word(uitfr_pkg::CMD_BYTE, 8'hff);
    offer_word(uitfr_pkg::CMD_TICK, 8'h00);
    offer_word(uitfr_pkg::CMD_CLEAR, 8'h00);
    drain_results();
    write_idle_limit(0);

    // ok prefix with cr lf trailer
    offer_word(uitfr_pkg::CMD_CLEAR, 8'h00);
    offer_word(uitfr_pkg::CMD_BYTE, uitfr_pkg::CH_O);
    offer_word(uitfr_pkg::CMD_BYTE, uitfr_pkg::CH_K);
    offer_word(uitfr_pkg::CMD_BYTE, uitfr_pkg::CH_CR);
    offer_word(uitfr_pkg::CMD_BYTE, uitfr_pkg::CH_LF);
    offer_ticks(3);
    // +wa prefix with gs cr trailer
    offer_word(uitfr_pkg::CMD_CLEAR, 8'h00);
    offer_word(uitfr_pkg::CMD_BYTE, uitfr_pkg::CH_PLUS);
    offer_word(uitfr_pkg::CMD_BYTE, uitfr_pkg::CH_W);
    offer_word(uitfr_pkg::CMD_BYTE, uitfr_pkg::CH_A);
    offer_word(uitfr_pkg::CMD_BYTE, uitfr_pkg::CH_GS);
    offer_word(uitfr_pkg::CMD_BYTE, uitfr_pkg::CH_CR);
    offer_ticks(3);
    // short frame: prefix present but too few bytes
    offer_word(uitfr_pkg::CMD_CLEAR, 8'h00);
    offer_word(uitfr_pkg::CMD_BYTE, uitfr_pkg::CH_O);
    offer_word(uitfr_pkg::CMD_BYTE, uitfr_pkg::CH_K);
    offer_ticks(3);

    run_phase(0, 0, 0, 1'b1);
    run_phase(67, 0, 2, 1'b0);
    run_phase(0, 67, 1, 1'b0);
    run_phase(23, 23, 5, 1'b0);

    // top limit: the frame stays pending through every tick
    drain_results();
    write_idle_limit(32'(uitfr_pkg::IDLE_WRAP));
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    offer_word(uitfr_pkg::CMD_BYTE, uitfr_pkg::CH_LF);
    offer_ticks(TOP_TICKS);

    drain_results();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
